/* src/pulse_rate_detector_unit_macros.svh */
`ifndef PULSE_RATE_DETECTOR_UNIT_MACROS_SVH
`define PULSE_RATE_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define PRD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define PRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/prd_pkg.sv */
`default_nettype none

package prd_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int LVL_W           = 12;
	localparam int OUT_W           = 12;
	localparam int HOLD_W          = 8;
	localparam int CNT_W           = 4;
	localparam int RATE_W          = 16;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int TRACK_START     = 2000;

	localparam logic [LVL_W-1:0]  CENTRE_RST   = 12'd2100;
	localparam logic [LVL_W-1:0]  BAND_RST     = 12'd40;
	localparam logic [HOLD_W-1:0] HOLDOFF_RST  = 8'd50;
	localparam logic [LVL_W-1:0]  LOW_RST      = 12'd370;
	localparam logic [LVL_W-1:0]  HIGH_RST     = 12'd3350;
	localparam logic [CNT_W-1:0]  CROSS_RST    = 4'd7;
	localparam logic [RATE_W-1:0] NUMER_RST    = 16'd45000;
	localparam logic [HOLD_W-1:0] RESTART_RST  = 8'd250;
	localparam logic [HOLD_W-1:0] BAD_HOLDOFF  = 8'd125;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTRE   = 3'd0,
		REG_BAND     = 3'd1,
		REG_HOLDOFF  = 3'd2,
		REG_LOW      = 3'd3,
		REG_HIGH     = 3'd4,
		REG_CROSS    = 3'd5,
		REG_NUMER    = 3'd6,
		REG_RESTART  = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [RATE_W-1:0] dividend;
		logic [RATE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [RATE_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* src/prd_channels.sv */
`default_nettype none

interface prd_in_if
	import prd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] red_sample;
	logic [SAMPLE_BITS-1:0] infra_sample;

	modport source (output valid, output red_sample, output infra_sample, input ready);
	modport sink (input valid, input red_sample, input infra_sample, output ready);
endinterface

interface prd_out_if
	import prd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              sample_bad;
	logic              rate_ready;
	logic [RATE_W-1:0] beats_per_minute;
	logic [RATE_W-1:0] mean_rate;
	logic [OUT_W-1:0]  red_minimum;
	logic [OUT_W-1:0]  red_maximum;
	logic [OUT_W-1:0]  infra_minimum;
	logic [OUT_W-1:0]  infra_maximum;

	modport source (output valid, output sample_bad, output rate_ready,
		output beats_per_minute, output mean_rate, output red_minimum,
		output red_maximum, output infra_minimum, output infra_maximum, input ready);
	modport sink (input valid, input sample_bad, input rate_ready,
		input beats_per_minute, input mean_rate, input red_minimum,
		input red_maximum, input infra_minimum, input infra_maximum, output ready);
endinterface

`default_nettype wire

/* src/pulse_rate_detector_unit.sv */
`default_nettype none

// Pulse rate detector. Takes one red/infrared sample word at a time and returns one result
// word for each. A word that needs no division goes from acceptance to ST_DONE, which loads
// it into the output register. A word that completes a rate measurement over a nonzero
// period passes through ST_DIV first: the 16-bit quotient numerator / period comes out of a
// restoring divider at one bit per cycle, ST_DIV sees the divider finish, then ST_DONE loads
// the result. The sample side is not ready from acceptance until the result is placed in
// the output register, which also waits for the previous result to be taken, so no new word
// is taken before the last one is through. Registers are to be written by the user through
// the plain write port only while the block is idle; the block does not enforce this.

module pulse_rate_detector_unit
	import prd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	prd_in_if.sink                    sample_in,
	prd_out_if.source                 result_out
);

	localparam int TRK_W = (SAMPLE_BITS > 11) ? SAMPLE_BITS : 11;
	localparam int CMP_W = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W;

	logic [LVL_W-1:0]  centre_q, band_q, low_lim_q, high_lim_q;
	logic [HOLD_W-1:0] holdoff_cfg_q, restart_q;
	logic [CNT_W-1:0]  cross_cfg_q;
	logic [RATE_W-1:0] numer_q;

	logic [CNT_W-1:0]  cross_cnt_q;
	logic [RATE_W-1:0] period_q;
	logic [HOLD_W-1:0] holdoff_q;
	logic              first_seen_q;
	logic              run_start_q;
	logic [TRK_W-1:0]  red_lo_q, red_hi_q, ir_lo_q, ir_hi_q;
	logic [RATE_W-1:0] avg_q, last_rate_q;
	logic              bad_q, hit_q;

	state_t state_q, state_d;
	logic   accept, load, need_div;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              out_valid_q;
	logic              out_bad_q, out_ready_q;
	logic [RATE_W-1:0] out_bpm_q, out_mean_q;
	logic [OUT_W-1:0]  out_rlo_q, out_rhi_q, out_ilo_q, out_ihi_q;

	logic [CMP_W-1:0]  red_c, cen_c, red_dev;
	logic [TRK_W-1:0]  red_t, ir_t;
	logic              bad;
	logic [CNT_W-1:0]  cc_e, cc_n;
	logic [RATE_W-1:0] ps_e, ps_n;
	logic [HOLD_W-1:0] ho_e, ho_n;
	logic              fs_e, fs_n, rs_e;
	logic [TRK_W-1:0]  rlo_n, rhi_n, ilo_n, ihi_n;
	logic [RATE_W-1:0] bpm, avg_n;
	logic [RATE_W:0]   avg_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q      <= CENTRE_RST;
			band_q        <= BAND_RST;
			holdoff_cfg_q <= HOLDOFF_RST;
			low_lim_q     <= LOW_RST;
			high_lim_q    <= HIGH_RST;
			cross_cfg_q   <= CROSS_RST;
			numer_q       <= NUMER_RST;
			restart_q     <= RESTART_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTRE:  centre_q      <= cfg_wdata[LVL_W-1:0];
				REG_BAND:    band_q        <= cfg_wdata[LVL_W-1:0];
				REG_HOLDOFF: holdoff_cfg_q <= cfg_wdata[HOLD_W-1:0];
				REG_LOW:     low_lim_q     <= cfg_wdata[LVL_W-1:0];
				REG_HIGH:    high_lim_q    <= cfg_wdata[LVL_W-1:0];
				REG_CROSS:   cross_cfg_q   <= cfg_wdata[CNT_W-1:0];
				REG_NUMER:   numer_q       <= cfg_wdata[RATE_W-1:0];
				REG_RESTART: restart_q     <= cfg_wdata[HOLD_W-1:0];
				default:     centre_q      <= centre_q;
			endcase
		end
	end

	always_comb begin
		red_c = CMP_W'(sample_in.red_sample);
		cen_c = CMP_W'(centre_q);
		red_t = TRK_W'(sample_in.red_sample);
		ir_t  = TRK_W'(sample_in.infra_sample);
		bad   = (red_c > CMP_W'(high_lim_q)) || (red_c < CMP_W'(low_lim_q));

		cc_e = bad ? '0 : cross_cnt_q;
		ps_e = bad ? '0 : period_q;
		fs_e = bad ? 1'b0 : first_seen_q;
		ho_e = bad ? BAD_HOLDOFF : holdoff_q;
		rs_e = bad | run_start_q;

		if (rs_e) begin
			rlo_n = TRK_W'(TRACK_START);
			rhi_n = TRK_W'(TRACK_START);
			ilo_n = TRK_W'(TRACK_START);
			ihi_n = TRK_W'(TRACK_START);
		end else begin
			rlo_n = (red_t < red_lo_q) ? red_t : red_lo_q;
			rhi_n = (red_t > red_hi_q) ? red_t : red_hi_q;
			ilo_n = (ir_t < ir_lo_q) ? ir_t : ir_lo_q;
			ihi_n = (ir_t > ir_hi_q) ? ir_t : ir_hi_q;
		end

		ps_n = (fs_e && (ps_e != '1)) ? ps_e + 1'b1 : ps_e;

		red_dev = (red_c >= cen_c) ? red_c - cen_c : cen_c - red_c;
		cc_n = cc_e;
		fs_n = fs_e;
		ho_n = ho_e;
		if (ho_e == '0) begin
			if (red_dev < CMP_W'(band_q)) begin
				cc_n = cc_e + 1'b1;
				fs_n = 1'b1;
				ho_n = holdoff_cfg_q;
			end
		end else begin
			ho_n = ho_e - 1'b1;
		end

		need_div = (cc_n == cross_cfg_q) && (ps_n != '0);
	end

	always_comb begin
		state_d          = state_q;
		sample_in.ready  = 1'b0;
		load             = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_in.ready = 1'b1;
				if (sample_in.valid) begin
					state_d = need_div ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result_out.ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = sample_in.valid && sample_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign div_req.start    = accept && need_div;
	assign div_req.dividend = numer_q;
	assign div_req.divisor  = ps_n;

	prd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign bpm     = (period_q == '0) ? '1 : div_rsp.quotient;
	assign avg_sum = {1'b0, avg_q} + {1'b0, bpm};
	assign avg_n   = (avg_q != '0) ? avg_sum[RATE_W:1] : bpm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_cnt_q  <= '0;
			period_q     <= '0;
			holdoff_q    <= '0;
			first_seen_q <= 1'b0;
			run_start_q  <= 1'b1;
			red_lo_q     <= '0;
			red_hi_q     <= '0;
			ir_lo_q      <= '0;
			ir_hi_q      <= '0;
			avg_q        <= '0;
			last_rate_q  <= '0;
			bad_q        <= 1'b0;
			hit_q        <= 1'b0;
		end else if (accept) begin
			cross_cnt_q  <= cc_n;
			period_q     <= ps_n;
			holdoff_q    <= ho_n;
			first_seen_q <= fs_n;
			run_start_q  <= 1'b0;
			red_lo_q     <= rlo_n;
			red_hi_q     <= rhi_n;
			ir_lo_q      <= ilo_n;
			ir_hi_q      <= ihi_n;
			bad_q        <= bad;
			hit_q        <= (cc_n == cross_cfg_q);
		end else if (load && hit_q) begin
			last_rate_q  <= bpm;
			avg_q        <= avg_n;
			cross_cnt_q  <= '0;
			period_q     <= '0;
			first_seen_q <= 1'b0;
			holdoff_q    <= restart_q;
			run_start_q  <= 1'b1;
			red_lo_q     <= '0;
			red_hi_q     <= '0;
			ir_lo_q      <= '0;
			ir_hi_q      <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_bad_q   <= bad_q;
			out_ready_q <= hit_q;
			out_bpm_q   <= hit_q ? bpm : last_rate_q;
			out_mean_q  <= hit_q ? avg_n : avg_q;
			out_rlo_q   <= OUT_W'(red_lo_q);
			out_rhi_q   <= OUT_W'(red_hi_q);
			out_ilo_q   <= OUT_W'(ir_lo_q);
			out_ihi_q   <= OUT_W'(ir_hi_q);
		end
	end

	assign result_out.valid            = out_valid_q;
	assign result_out.sample_bad       = out_bad_q;
	assign result_out.rate_ready       = out_ready_q;
	assign result_out.beats_per_minute = out_bpm_q;
	assign result_out.mean_rate        = out_mean_q;
	assign result_out.red_minimum      = out_rlo_q;
	assign result_out.red_maximum      = out_rhi_q;
	assign result_out.infra_minimum    = out_ilo_q;
	assign result_out.infra_maximum    = out_ihi_q;

`include "pulse_rate_detector_unit_macros.svh"

	`PRD_ASSERT_IMPLY(a_div_done_in_div, div_rsp.done, state_q == ST_DIV, "divider done outside divide")
	`PRD_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE, "accepted word left block idle")
	`PRD_ASSERT_IMPLY(a_period_needs_first, !first_seen_q, period_q == '0, "period counted before crossing")
	`PRD_ASSERT_IMPLY(a_rate_matches_last, out_valid_q && out_ready_q, out_bpm_q == last_rate_q, "rate word differs from last rate")

endmodule

`default_nettype wire

/* src/prd_divider.sv */
`default_nettype none

module prd_divider
	import prd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_DW = $clog2(RATE_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_DW-1:0] cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] quot_q;
	logic [RATE_W-1:0] divisor_q;
	logic [RATE_W:0]   shifted;
	logic [RATE_W:0]   diff;
	logic              fits;

	assign shifted = {rem_q, quot_q[RATE_W-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_DW'(RATE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quot_q    <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
			quot_q <= {quot_q[RATE_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import prd_pkg::*;

	localparam int SB            = SAMPLE_BITS_DEF;
	localparam int HALF_PERIOD   = 4;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 300;
	localparam int NUM_PHASES    = 12;

	localparam logic [LVL_W-1:0] TRACK_LVL = LVL_W'(TRACK_START);

	typedef struct packed {
		logic              bad;
		logic              done;
		logic [RATE_W-1:0] bpm;
		logic [RATE_W-1:0] mean;
		logic [OUT_W-1:0]  red_lo;
		logic [OUT_W-1:0]  red_hi;
		logic [OUT_W-1:0]  ir_lo;
		logic [OUT_W-1:0]  ir_hi;
	} rate_word_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		cfg_reg_t         idx;
		logic [CFG_W-1:0] val;
		logic [SB-1:0]    red;
		logic [SB-1:0]    ir;
		bit               typed;
		rate_word_t       want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	prd_in_if #(.SAMPLE_BITS(SB)) in_ch ();
	prd_out_if out_ch ();

	pulse_rate_detector_unit #(.SAMPLE_BITS(SB)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.sample_in  (in_ch),
		.result_out (out_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	logic [LVL_W-1:0]  c_centre, c_band, c_low, c_high;
	logic [HOLD_W-1:0] c_holdoff, c_restart;
	logic [CNT_W-1:0]  c_target;
	logic [RATE_W-1:0] c_numer;

	logic [CNT_W-1:0]  s_crossings;
	logic [RATE_W-1:0] s_period;
	logic [HOLD_W-1:0] s_hold;
	logic              s_armed, s_fresh;
	logic [LVL_W-1:0]  s_red_lo, s_red_hi, s_ir_lo, s_ir_hi;
	logic [RATE_W-1:0] s_mean, s_last;

	rate_word_t pending_words[$];
	int         mismatches = 0;
	int         stall_cycles = 0;
	bit         quiet = 1'b0;
	bit         long_hold_req = 1'b0;

	function automatic void restart_run(logic [HOLD_W-1:0] hold);
		s_crossings = '0;
		s_period    = '0;
		s_armed     = 1'b0;
		s_hold      = hold;
		s_fresh     = 1'b1;
	endfunction

	function automatic rate_word_t predict_rate(logic [SB-1:0] red, logic [SB-1:0] ir);
		rate_word_t       w;
		logic [LVL_W-1:0] red_dev;
		logic [RATE_W:0]  sum;
		w = '0;
		w.bad = (red > c_high) || (red < c_low);
		if (w.bad)
			restart_run(BAD_HOLDOFF);
		if (s_fresh) begin
			s_red_lo = TRACK_LVL;
			s_red_hi = TRACK_LVL;
			s_ir_lo  = TRACK_LVL;
			s_ir_hi  = TRACK_LVL;
		end else begin
			if (red < s_red_lo) s_red_lo = red;
			if (red > s_red_hi) s_red_hi = red;
			if (ir < s_ir_lo) s_ir_lo = ir;
			if (ir > s_ir_hi) s_ir_hi = ir;
		end
		if (s_armed && s_period != '1)
			s_period = s_period + 1'b1;
		red_dev = (red >= c_centre) ? red - c_centre : c_centre - red;
		if (s_hold == '0) begin
			if (red_dev < c_band) begin
				s_crossings = s_crossings + 1'b1;
				s_armed     = 1'b1;
				s_hold      = c_holdoff;
			end
		end else begin
			s_hold = s_hold - 1'b1;
		end
		s_fresh = 1'b0;
		if (s_crossings == c_target) begin
			s_last = (s_period == '0) ? '1 : c_numer / s_period;
			if (s_mean != '0) begin
				sum    = {1'b0, s_mean} + {1'b0, s_last};
				s_mean = sum[RATE_W:1];
			end else begin
				s_mean = s_last;
			end
			w.done = 1'b1;
		end
		w.bpm    = s_last;
		w.mean   = s_mean;
		w.red_lo = s_red_lo;
		w.red_hi = s_red_hi;
		w.ir_lo  = s_ir_lo;
		w.ir_hi  = s_ir_hi;
		if (w.done) begin
			restart_run(c_restart);
			s_red_lo = '0;
			s_red_hi = '0;
			s_ir_lo  = '0;
			s_ir_hi  = '0;
		end
		return w;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = int'($urandom_range(99, 0));
		if (r < 45)
			return 0;
		if (r < 85)
			return int'($urandom_range(3, 1));
		if (r < 97)
			return int'($urandom_range(10, 4));
		return int'($urandom_range(40, 11));
	endfunction

	function automatic logic [SB-1:0] pick_red();
		int r, v, span;
		r = int'($urandom_range(99, 0));
		if (r < 40) begin
			span = (c_band == '0) ? 0 : int'(c_band) - 1;
			v = int'(c_centre) - span + int'($urandom_range(2 * span, 0));
			if (v < 0) v = 0;
			if (v > 4095) v = 4095;
		end else if (r < 85 && c_low <= c_high) begin
			v = int'($urandom_range(c_high, c_low));
		end else begin
			v = int'($urandom_range(4095, 0));
		end
		return SB'(v);
	endfunction

	function automatic logic [SB-1:0] pick_ir();
		int r;
		r = int'($urandom_range(99, 0));
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return SB'($urandom_range(4095, 0));
	endfunction

	function automatic string word_text(rate_word_t w);
		return $sformatf("bad=%0b rdy=%0b bpm=%0d mean=%0d red=%0d/%0d ir=%0d/%0d",
			w.bad, w.done, w.bpm, w.mean, w.red_lo, w.red_hi, w.ir_lo, w.ir_hi);
	endfunction

	function automatic stim_row_t row_write(cfg_reg_t idx, logic [CFG_W-1:0] val);
		stim_row_t r;
		r = '{ROW_WRITE, idx, val, '0, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t row_word(logic [SB-1:0] red, logic [SB-1:0] ir);
		stim_row_t r;
		r = '{ROW_SAMPLE, REG_CENTRE, '0, red, ir, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t row_check(logic [SB-1:0] red, logic [SB-1:0] ir,
		rate_word_t want);
		stim_row_t r;
		r = '{ROW_SAMPLE, REG_CENTRE, '0, red, ir, 1'b1, want};
		return r;
	endfunction

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_CENTRE:  c_centre  = val[LVL_W-1:0];
			REG_BAND:    c_band    = val[LVL_W-1:0];
			REG_HOLDOFF: c_holdoff = val[HOLD_W-1:0];
			REG_LOW:     c_low     = val[LVL_W-1:0];
			REG_HIGH:    c_high    = val[LVL_W-1:0];
			REG_CROSS:   c_target  = val[CNT_W-1:0];
			REG_NUMER:   c_numer   = val;
			REG_RESTART: c_restart = val[HOLD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_one(cfg_reg_t idx, logic [CFG_W-1:0] val);
		wait_idle();
		write_reg(idx, val);
		cfg_we <= 1'b0;
	endtask

	task automatic drive_word(logic [SB-1:0] red, logic [SB-1:0] ir, bit typed,
		rate_word_t want);
		int         gap;
		rate_word_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.red_sample   <= red;
		in_ch.infra_sample <= ir;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pred = predict_rate(red, ir);
		pending_words.push_back(typed ? want : pred);
	endtask

	initial begin
		stim_row_t        rows[$];
		logic [CFG_W-1:0] plan [8];
		int               n;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		in_ch.valid        = 1'b0;
		in_ch.red_sample   = '0;
		in_ch.infra_sample = '0;
		out_ch.ready       = 1'b0;
		c_centre  = CENTRE_RST;
		c_band    = BAND_RST;
		c_holdoff = HOLDOFF_RST;
		c_low     = LOW_RST;
		c_high    = HIGH_RST;
		c_target  = CROSS_RST;
		c_numer   = NUMER_RST;
		c_restart = RESTART_RST;
		restart_run('0);
		s_red_lo = '0;
		s_red_hi = '0;
		s_ir_lo  = '0;
		s_ir_hi  = '0;
		s_mean   = '0;
		s_last   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: first crossing, both limits, out-of-range words
		rows.push_back(row_check(12'd2100, 12'd0,
			'{1'b0, 1'b0, 16'd0, 16'd0, 12'd2000, 12'd2000, 12'd2000, 12'd2000}));
		rows.push_back(row_check(12'd0, 12'd4095,
			'{1'b1, 1'b0, 16'd0, 16'd0, 12'd2000, 12'd2000, 12'd2000, 12'd2000}));
		rows.push_back(row_check(12'd4095, 12'd0,
			'{1'b1, 1'b0, 16'd0, 16'd0, 12'd2000, 12'd2000, 12'd2000, 12'd2000}));
		rows.push_back(row_check(12'd370, 12'd4095,
			'{1'b0, 1'b0, 16'd0, 16'd0, 12'd370, 12'd2000, 12'd2000, 12'd4095}));
		rows.push_back(row_check(12'd3350, 12'd0,
			'{1'b0, 1'b0, 16'd0, 16'd0, 12'd370, 12'd3350, 12'd0, 12'd4095}));
		rows.push_back(row_check(12'd369, 12'd2000,
			'{1'b1, 1'b0, 16'd0, 16'd0, 12'd2000, 12'd2000, 12'd2000, 12'd2000}));
		rows.push_back(row_check(12'd3351, 12'd2000,
			'{1'b1, 1'b0, 16'd0, 16'd0, 12'd2000, 12'd2000, 12'd2000, 12'd2000}));
		// zero crossing target: result on every word with zero period
		rows.push_back(row_write(REG_CROSS, 16'd0));
		rows.push_back(row_write(REG_RESTART, 16'd0));
		rows.push_back(row_check(12'd2100, 12'd100,
			'{1'b0, 1'b1, 16'd65535, 16'd65535, 12'd2000, 12'd2100, 12'd100, 12'd2000}));
		rows.push_back(row_check(12'd4095, 12'd4095,
			'{1'b1, 1'b1, 16'd65535, 16'd65535, 12'd2000, 12'd2000, 12'd2000, 12'd2000}));
		// short periods, band edges, mean update
		rows.push_back(row_write(REG_CROSS, 16'd2));
		rows.push_back(row_write(REG_HOLDOFF, 16'd0));
		rows.push_back(row_word(12'd2100, 12'd5));
		rows.push_back(row_word(12'd2100, 12'd4090));
		rows.push_back(row_word(12'd2090, 12'd4000));
		rows.push_back(row_word(12'd2139, 12'd1));
		rows.push_back(row_word(12'd2140, 12'd2));
		// out-of-range word inside the band
		rows.push_back(row_write(REG_LOW, 16'd100));
		rows.push_back(row_write(REG_CENTRE, 16'd0));
		rows.push_back(row_write(REG_BAND, 16'd4095));
		rows.push_back(row_word(12'd50, 12'd4095));
		rows.push_back(row_word(12'd100, 12'd0));
		// low limit above high limit
		rows.push_back(row_write(REG_LOW, 16'd3000));
		rows.push_back(row_write(REG_HIGH, 16'd1000));
		rows.push_back(row_word(12'd2000, 12'd2048));
		rows.push_back(row_word(12'd3000, 12'd1));
		rows.push_back(row_word(12'd1000, 12'd4094));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE)
				write_one(rows[i].idx, rows[i].val);
			else
				drive_word(rows[i].red, rows[i].ir, rows[i].typed, rows[i].want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 0) begin
				plan = '{16'd4095, 16'd4095, 16'd255, 16'd4095, 16'd4095, 16'd15,
					16'd65535, 16'd255};
			end else if (ph == 1) begin
				plan = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0};
			end else if (ph == 2) begin
				plan = '{CFG_W'($urandom_range(4095, 0)), 16'd4095, 16'd0, 16'd0,
					16'd4095, CFG_W'($urandom_range(3, 1)),
					CFG_W'($urandom_range(65535, 1)), 16'd0};
			end else begin
				plan = '{CFG_W'($urandom_range(3600, 500)),
					CFG_W'(($urandom_range(9, 0) == 0) ? 4095 : $urandom_range(300, 1)),
					CFG_W'(($urandom_range(4, 0) == 0) ? $urandom_range(255, 0)
						: $urandom_range(12, 0)),
					CFG_W'($urandom_range(600, 0)),
					CFG_W'($urandom_range(4095, 3000)),
					CFG_W'(($urandom_range(4, 0) == 0) ? $urandom_range(15, 1)
						: $urandom_range(4, 1)),
					CFG_W'($urandom_range(65535, 1)),
					CFG_W'(($urandom_range(4, 0) == 0) ? $urandom_range(255, 0)
						: $urandom_range(10, 0))};
			end
			wait_idle();
			for (int i = 0; i < 8; i++)
				write_reg(cfg_reg_t'(i), plan[i]);
			cfg_we <= 1'b0;
			quiet = (ph == 4);
			n = (ph < 2) ? 30 : 109;
			for (int k = 0; k < n; k++) begin
				if (ph == 5 && k == 40)
					long_hold_req = 1'b1;
				if (ph == 7 && k == 60)
					wait_idle();
				drive_word(pick_red(), pick_ir(), 1'b0, '0);
			end
		end
		quiet = 1'b0;

		wait_idle();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : result_sink
		int         gap;
		rate_word_t got, want;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap();
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
			got = '{out_ch.sample_bad, out_ch.rate_ready, out_ch.beats_per_minute,
				out_ch.mean_rate, out_ch.red_minimum, out_ch.red_maximum,
				out_ch.infra_minimum, out_ch.infra_maximum};
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: %s", word_text(got));
			end else begin
				want = pending_words.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %s, got %s",
							word_text(want), word_text(got));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

/* filelist.f */
+incdir+src
src/prd_pkg.sv
src/prd_channels.sv
src/prd_divider.sv
src/pulse_rate_detector_unit.sv
verif/tb_top.sv
